@@ rtl/core/assert_macros.svh @@
// Assertion macros included by the unmasker RTL.
// WSFU_ASSERT_DIS checks a property on a given clock with an active-low reset.
// WSFU_ASSERT uses the usual clk_i and rst_ni of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define WSFU_ASSERT_DIS(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

`define WSFU_ASSERT(name, prop) \
  `WSFU_ASSERT_DIS(name, clk_i, rst_ni, prop)

`endif

@@ rtl/core/wsfu_pkg.sv @@
// ---------------------------------------------------------------------------
// wsfu_pkg: shared types and constants of the WebSocket frame unmasker
// Field widths of the byte stream and the result, and header length codes.
// ---------------------------------------------------------------------------
package wsfu_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned OpcodeW  = 4;
  localparam int unsigned LenCodeW = 7;
  localparam int unsigned LenW     = 16;
  localparam int unsigned MsgNumW  = 16;
  localparam int unsigned KeyW     = 32;

  // Length codes of the second header byte.
  localparam logic [LenCodeW-1:0] LenCodeExt16 = 7'd126;
  localparam logic [LenCodeW-1:0] LenCodeExt64 = 7'd127;

  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [OpcodeW-1:0] opcode_t;
  typedef logic [LenW-1:0]    len_t;
  typedef logic [MsgNumW-1:0] msg_num_t;

endpackage

@@ rtl/core/websocket_frame_unmasker_top.sv @@
// ---------------------------------------------------------------------------
// websocket_frame_unmasker_top: client frame deframer and payload unmasker
// Parses frame headers byte by byte and emits unmasked payload bytes.
// ---------------------------------------------------------------------------
// Usage: received frame bytes enter one per request on the in channel
// (in_valid_i, in_ready_o, rx_byte_i). Header bytes, extended length bytes
// and the four mask key bytes give no result. Each payload byte gives one
// result on the out channel with the opcode, a last-byte mark and the
// running message number. A frame of zero length gives one result marked
// empty. Length code 127 gives one result with bad_length_o set, after
// which every byte is taken and dropped until reset.
// A result is valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle when not stalled; the header parse, counter
// update and key XOR sit between the input handshake and a single result
// register. When the receiver stalls, the result register holds and in_ready_o
// drops until that result is taken; a stall never loses or repeats a result.
// Reset clears the parser to expect the first header byte, the message
// count to zero and the result register to empty.
// ---------------------------------------------------------------------------
module websocket_frame_unmasker_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [wsfu_pkg::ByteW-1:0]   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [wsfu_pkg::ByteW-1:0]   payload_byte_o,
  output logic [wsfu_pkg::OpcodeW-1:0] frame_opcode_o,
  output logic                         last_byte_o,
  output logic                         empty_message_o,
  output logic                         bad_length_o,
  output logic [wsfu_pkg::MsgNumW-1:0] message_number_o
);
  import wsfu_pkg::*;

  typedef enum logic [3:0] {
    PhHdr0,
    PhHdr1,
    PhExtHi,
    PhExtLo,
    PhKey0,
    PhKey1,
    PhKey2,
    PhKey3,
    PhData,
    PhHalt
  } phase_e;

  phase_e              phase_q, phase_d;
  opcode_t             opcode_q, opcode_d;
  len_t                rem_q, rem_d;
  logic [KeyW-1:0]     key_q, key_d;
  logic [1:0]          kpos_q, kpos_d;
  msg_num_t            msg_q, msg_d;
  msg_num_t            msg_plus;
  logic [LenCodeW-1:0] len_code;
  byte_t               key_byte;

  logic     emit;
  byte_t    res_byte;
  logic     res_last, res_empty, res_bad;
  msg_num_t res_num;

  logic     out_valid_q;
  byte_t    out_byte_q;
  opcode_t  out_opcode_q;
  logic     out_last_q, out_empty_q, out_bad_q;
  msg_num_t out_num_q;

  logic in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign len_code = rx_byte_i[LenCodeW-1:0];
  assign msg_plus = msg_q + 1'b1;
  // Key byte 0 is the first one received, so it sits in the top byte.
  assign key_byte = key_q[{~kpos_q, 3'b000} +: ByteW];

  always_comb begin
    phase_d   = phase_q;
    opcode_d  = opcode_q;
    rem_d     = rem_q;
    key_d     = key_q;
    kpos_d    = kpos_q;
    msg_d     = msg_q;
    emit      = 1'b0;
    res_byte  = '0;
    res_last  = 1'b0;
    res_empty = 1'b0;
    res_bad   = 1'b0;
    res_num   = msg_q;
    unique case (phase_q)
      PhHdr0: begin
        opcode_d = rx_byte_i[OpcodeW-1:0];
        phase_d  = PhHdr1;
      end
      PhHdr1: begin
        if (len_code < LenCodeExt16) begin
          rem_d   = {{(LenW-LenCodeW){1'b0}}, len_code};
          phase_d = PhKey0;
        end else if (len_code == LenCodeExt16) begin
          phase_d = PhExtHi;
        end else begin
          phase_d = PhHalt;
          emit    = 1'b1;
          res_bad = 1'b1;
        end
      end
      PhExtHi: begin
        rem_d   = {rx_byte_i, {(LenW-ByteW){1'b0}}};
        phase_d = PhExtLo;
      end
      PhExtLo: begin
        rem_d   = {rem_q[LenW-1:ByteW], rx_byte_i};
        phase_d = PhKey0;
      end
      PhKey0, PhKey1, PhKey2: begin
        key_d   = {key_q[KeyW-ByteW-1:0], rx_byte_i};
        phase_d = phase_e'(phase_q + 4'd1);
      end
      PhKey3: begin
        key_d  = {key_q[KeyW-ByteW-1:0], rx_byte_i};
        kpos_d = '0;
        if (rem_q == '0) begin
          msg_d     = msg_plus;
          phase_d   = PhHdr0;
          emit      = 1'b1;
          res_last  = 1'b1;
          res_empty = 1'b1;
          res_num   = msg_plus;
        end else begin
          phase_d = PhData;
        end
      end
      PhData: begin
        kpos_d   = kpos_q + 2'd1;
        rem_d    = rem_q - 1'b1;
        emit     = 1'b1;
        res_byte = rx_byte_i ^ key_byte;
        res_num  = msg_plus;
        if (rem_q == len_t'(1)) begin
          msg_d    = msg_plus;
          phase_d  = PhHdr0;
          res_last = 1'b1;
        end
      end
      PhHalt: begin
        phase_d = PhHalt;
      end
      default: begin
        phase_d = PhHalt;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHdr0;
      opcode_q <= '0;
      rem_q    <= '0;
      key_q    <= '0;
      kpos_q   <= '0;
      msg_q    <= '0;
    end else if (in_fire) begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      rem_q    <= rem_d;
      key_q    <= key_d;
      kpos_q   <= kpos_d;
      msg_q    <= msg_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // The opcode comes from the held value, so an error result carries the
  // opcode of the frame whose header held the bad code.
  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      out_byte_q   <= res_byte;
      out_opcode_q <= opcode_q;
      out_last_q   <= res_last;
      out_empty_q  <= res_empty;
      out_bad_q    <= res_bad;
      out_num_q    <= res_num;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign payload_byte_o   = out_byte_q;
  assign frame_opcode_o   = out_opcode_q;
  assign last_byte_o      = out_last_q;
  assign empty_message_o  = out_empty_q;
  assign bad_length_o     = out_bad_q;
  assign message_number_o = out_num_q;

`include "assert_macros.svh"

  `WSFU_ASSERT(a_bad_result_clean, (out_valid_o && bad_length_o) |-> (!last_byte_o && !empty_message_o && (payload_byte_o == '0)))
  `WSFU_ASSERT(a_empty_is_last, (out_valid_o && empty_message_o) |-> (last_byte_o && !bad_length_o))
  `WSFU_ASSERT(a_halt_is_silent, (phase_q == PhHalt && !out_valid_q) |=> (!out_valid_q && phase_q == PhHalt))
  `WSFU_ASSERT(a_count_on_last, (in_fire && emit && res_last) |=> (msg_q == $past(msg_q) + 1'b1))

endmodule

@@ tb/sv/websocket_frame_unmasker_top_test.sv @@
// ---------------------------------------------------------------------------
// websocket_frame_unmasker_top_test: self-checking bench for the frame unmasker
// Streams client frames into the block and checks every result against a
// frame parser kept in the bench: short and extended lengths, zero-length
// frames, random masks and payloads, and the unsupported 64-bit length
// code, which stops the block for the rest of the run.
// ---------------------------------------------------------------------------
module websocket_frame_unmasker_top_test;
  import wsfu_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned PhaseBytes    = 72;
  localparam logic [LenCodeW-1:0] MaxShortLen = LenCodeExt16 - 7'd1;

  typedef enum logic [2:0] {
    PsHdr0, PsHdr1, PsExtHi, PsExtLo, PsKey, PsData, PsHalted
  } parse_state_e;

  typedef struct packed {
    byte_t    payload;
    opcode_t  opcode;
    logic     last;
    logic     empty;
    logic     bad;
    msg_num_t number;
  } unmasked_t;

  class unmask_scoreboard;
    parse_state_e state;
    opcode_t      opcode;
    len_t         remaining;
    logic [KeyW-1:0] key;
    logic [1:0]   key_pos;
    int unsigned  key_count;
    msg_num_t     msgs_done;
    unmasked_t    unmasked_q[$];
    int unsigned  errors;

    function new();
      state         = PsHdr0;
      opcode        = '0;
      remaining     = '0;
      key           = '0;
      key_pos       = '0;
      key_count     = 0;
      msgs_done     = '0;
      errors        = 0;
    endfunction

    function void queue_result(byte_t payload, logic last, logic empty, logic bad,
                               msg_num_t number);
      unmasked_t r;
      r.payload = payload;
      r.opcode  = opcode;
      r.last    = last;
      r.empty   = empty;
      r.bad     = bad;
      r.number  = number;
      unmasked_q.push_back(r);
    endfunction

    function void finish_message();
      msgs_done = msgs_done + 1'b1;
      state = PsHdr0;
    endfunction

    // Advances the frame parser by one accepted byte.
    function void take_rx_byte(byte_t b);
      byte_t key_byte;
      case (state)
        PsHdr0: begin
          opcode = b[OpcodeW-1:0];
          state  = PsHdr1;
        end
        PsHdr1: begin
          if (b[LenCodeW-1:0] == LenCodeExt64) begin
            state = PsHalted;
            queue_result('0, 1'b0, 1'b0, 1'b1, msgs_done);
          end else if (b[LenCodeW-1:0] == LenCodeExt16) begin
            state = PsExtHi;
          end else begin
            remaining = len_t'(b[LenCodeW-1:0]);
            key_count = 0;
            state     = PsKey;
          end
        end
        PsExtHi: begin
          remaining = {b, 8'h00};
          state     = PsExtLo;
        end
        PsExtLo: begin
          remaining[7:0] = b;
          key_count      = 0;
          state          = PsKey;
        end
        PsKey: begin
          key = {key[KeyW-9:0], b};
          key_count++;
          if (key_count == 4) begin
            key_pos = '0;
            if (remaining == '0) begin
              finish_message();
              queue_result('0, 1'b1, 1'b1, 1'b0, msgs_done);
            end else begin
              state = PsData;
            end
          end
        end
        PsData: begin
          // The first key byte received masks payload bytes 0, 4, 8 and so on.
          key_byte  = key[8*(3-key_pos) +: 8];
          key_pos   = key_pos + 1'b1;
          remaining = remaining - 1'b1;
          if (remaining == '0) begin
            finish_message();
            queue_result(b ^ key_byte, 1'b1, 1'b0, 1'b0, msgs_done);
          end else begin
            queue_result(b ^ key_byte, 1'b0, 1'b0, 1'b0, msgs_done + 1'b1);
          end
        end
        default: ;
      endcase
    endfunction

    function string show(unmasked_t r);
      return $sformatf("byte=%h op=%h last=%b empty=%b bad=%b num=%h",
                       r.payload, r.opcode, r.last, r.empty, r.bad, r.number);
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_unmasked(unmasked_t got);
      unmasked_t want;
      bit        differs;
      if (unmasked_q.size() == 0) begin
        note_error({"unexpected result: ", show(got)});
        return;
      end
      want    = unmasked_q.pop_front();
      differs = (got.payload !== want.payload) || (got.opcode !== want.opcode) ||
                (got.last !== want.last) || (got.empty !== want.empty) ||
                (got.bad !== want.bad) || (got.number !== want.number);
      if (differs) begin
        note_error({"result mismatch: expected ", show(want), " got ", show(got)});
      end
    endfunction

    function int unsigned pending();
      return unmasked_q.size();
    endfunction
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  byte_t    rx_byte_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  byte_t    payload_byte_o;
  opcode_t  frame_opcode_o;
  logic     last_byte_o;
  logic     empty_message_o;
  logic     bad_length_o;
  msg_num_t message_number_o;

  unmask_scoreboard sb = new();
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned rx_sent   = 0;
  int unsigned quiet_cycles = 0;
  byte_t       body_q[$];

  websocket_frame_unmasker_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .payload_byte_o   (payload_byte_o),
    .frame_opcode_o   (frame_opcode_o),
    .last_byte_o      (last_byte_o),
    .empty_message_o  (empty_message_o),
    .bad_length_o     (bad_length_o),
    .message_number_o (message_number_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Results are checked before the byte of the same edge is noted, since a
  // result always belongs to an earlier byte.
  always @(posedge clk_i) begin
    unmasked_t got;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.payload = payload_byte_o;
        got.opcode  = frame_opcode_o;
        got.last    = last_byte_o;
        got.empty   = empty_message_o;
        got.bad     = bad_length_o;
        got.number  = message_number_o;
        sb.check_unmasked(got);
      end
      if (in_valid_i && in_ready_o) sb.take_rx_byte(rx_byte_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("websocket_frame_unmasker_top_test: errors");
      $finish;
    end
  end

  task automatic send_byte(input byte_t b);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    rx_sent++;
  endtask

  // Payload bytes come from body_q while it holds any, otherwise at random.
  task automatic send_frame(input byte_t hdr0, input byte_t hdr1, input len_t ext_len,
                            input logic [KeyW-1:0] key);
    len_t n;
    send_byte(hdr0);
    send_byte(hdr1);
    if (hdr1[LenCodeW-1:0] == LenCodeExt64) return;
    if (hdr1[LenCodeW-1:0] == LenCodeExt16) begin
      send_byte(ext_len[15:8]);
      send_byte(ext_len[7:0]);
      n = ext_len;
    end else begin
      n = len_t'(hdr1[LenCodeW-1:0]);
    end
    for (int k = 3; k >= 0; k--) send_byte(key[8*k +: 8]);
    for (int unsigned i = 0; i < n; i++) begin
      send_byte(body_q.size() != 0 ? body_q.pop_front() : byte_t'($urandom_range(255)));
    end
  endtask

  task automatic send_random_frame();
    byte_t       hdr1;
    len_t        ext_len;
    int unsigned pick;
    pick    = $urandom_range(99);
    ext_len = '0;
    hdr1    = '0;
    if (pick < 70) begin
      hdr1[LenCodeW-1:0] = LenCodeW'($urandom_range(12, 1));
    end else if (pick < 78) begin
      hdr1[LenCodeW-1:0] = LenCodeW'($urandom_range(MaxShortLen, 13));
    end else if (pick < 86) begin
      hdr1[LenCodeW-1:0] = LenCodeExt16;
      ext_len = (pick < 80) ? len_t'(0) : len_t'($urandom_range(160));
    end
    hdr1[7] = 1'($urandom_range(1));
    send_frame(byte_t'($urandom_range(255)), hdr1, ext_len, $urandom());
  endtask

  initial begin
    int unsigned idle_set[4];
    int unsigned stall_set[4];
    idle_set  = '{0, 53, 0, 26};
    stall_set = '{0, 0, 53, 26};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Opcode and key extremes, an empty short frame and an empty extended one.
    send_frame(8'h00, 8'h00, '0, 32'h0000_0000);
    body_q = '{8'hFF, 8'hFF, 8'h00, 8'h00};
    send_frame(8'hFF, 8'h84, '0, 32'hFF00_FF00);
    send_frame(8'h81, {1'b1, LenCodeExt16}, 16'h0000, 32'hFFFF_FFFF);

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_set[p];
      stall_pct = stall_set[p];
      rx_sent   = 0;
      while (rx_sent < PhaseBytes) send_random_frame();
    end

    // The longest short length and an extended length with a nonzero high
    // byte, run without idling.
    idle_pct  = 0;
    stall_pct = 0;
    send_frame(byte_t'($urandom_range(255)), {1'b0, MaxShortLen}, '0, $urandom());
    send_frame(byte_t'($urandom_range(255)), {1'b1, LenCodeExt16}, 16'h0102, $urandom());
    idle_pct  = 26;
    stall_pct = 26;
    repeat (3) send_random_frame();

    // The 64-bit length code stops the block, so it comes last; the bytes
    // after it must be taken without any result.
    send_frame(byte_t'($urandom_range(255)), {1'b1, LenCodeExt64}, '0, '0);
    repeat (8) send_byte(byte_t'($urandom_range(255)));
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("websocket_frame_unmasker_top_test: clean");
    end else begin
      $display("websocket_frame_unmasker_top_test: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/wsfu_pkg.sv
rtl/core/websocket_frame_unmasker_top.sv
tb/sv/websocket_frame_unmasker_top_test.sv
